### hdl/tgrc_pkg.sv
// Shared types and constants for the tile grid rectangle collision block.
// No dependencies; imported by tile_grid_rect_collision and the testbench.
package tgrc_pkg;

  // Field widths fixed by the item and register formats
  localparam int KIND_W  = 2;
  localparam int ID_W    = 6;
  localparam int POS_W   = 7;
  localparam int CFG_W   = 7;
  localparam int CIDX_W  = 3;
  // Holds pos + size of two 7-bit fields and any grid size up to 256
  localparam int SPAN_W  = 9;
  // Ids are 6 bits, so at most this many saved-position slots are reachable
  localparam int ID_SPAN = 64;

  // Item kinds
  localparam logic [KIND_W-1:0] K_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] K_PLACE  = 2'd1;
  localparam logic [KIND_W-1:0] K_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] K_QUERY  = 2'd3;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] R_GRID_W   = 3'd0;
  localparam logic [CIDX_W-1:0] R_GRID_H   = 3'd1;
  localparam logic [CIDX_W-1:0] R_BORDER_L = 3'd2;
  localparam logic [CIDX_W-1:0] R_BORDER_T = 3'd3;
  localparam logic [CIDX_W-1:0] R_BORDER_I = 3'd4;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_CLEAR = 5'b00100,
    S_RUN   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

### hdl/tile_grid_rect_collision.sv
// Top level of the occupancy grid collision block: sequencer, row datapath,
// configuration registers. Depends on tgrc_pkg and tgrc_ram.
//
// Usage:
// - Input channel (in_valid / in_stall): one beat is one command: clear grid,
//   place object, remove object or collision query. in_stall is high while a
//   command is in progress; one command is worked on at a time.
// - Result channel (out_valid / out_stall): exactly one result beat per
//   command, held in an output register until taken.
// - Config port: cfg_we writes cfg_wdata to register cfg_index; write only
//   while idle. Indexes beyond the register list are ignored.
// - The grid lives in a RAM with one row of cells per word; the shared row
//   unit reads, merges or scans and writes back one row per cycle.
// - Work per command: clear writes every row of the store (one write per
//   row); place, remove and query walk the rectangle's rows in order;
//   out-of-bounds or empty rectangles finish without touching the grid. A
//   query stops at the first row that holds a hit. The next command is
//   taken in the cycle after the result is registered.
// - Reset: rst_n is synchronous; registers return to their defaults and all
//   grid rows and saved positions read as zero through row/slot valid bits.
// - A stalled result holds the finished command in the sequencer; no new
//   command is taken until the output register frees up.
module tile_grid_rect_collision #(
  parameter int GRID_MAX_W  = 64,
  parameter int GRID_MAX_H  = 64,
  parameter int MAX_OBJECTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tgrc_pkg::KIND_W-1:0]   in_kind,
  input  logic [tgrc_pkg::ID_W-1:0]     in_obj_id,
  input  logic [tgrc_pkg::POS_W-1:0]    in_pos_x,
  input  logic [tgrc_pkg::POS_W-1:0]    in_pos_y,
  input  logic [tgrc_pkg::POS_W-1:0]    in_size_x,
  input  logic [tgrc_pkg::POS_W-1:0]    in_size_y,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic                          out_hit,
  output logic [tgrc_pkg::ID_W-1:0]     out_hit_id,
  // configuration port
  input  logic                          cfg_we,
  input  logic [tgrc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tgrc_pkg::CFG_W-1:0]    cfg_wdata
);

  import tgrc_pkg::*;

  localparam int YW     = $clog2(GRID_MAX_H);
  localparam int ROW_W  = GRID_MAX_W * ID_W;
  localparam int SW     = $clog2(MAX_OBJECTS);
  localparam int NSLOT  = (MAX_OBJECTS < ID_SPAN) ? MAX_OBJECTS : ID_SPAN;
  localparam int VW     = $clog2(NSLOT);

  // configuration registers
  logic [CFG_W-1:0] grid_w_r, grid_h_r, border_l_r, border_t_r;
  logic [ID_W-1:0]  border_id_r;

  // sequencer and command registers
  state_t            state_r, state_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [ID_W-1:0]   id_r;
  logic [POS_W-1:0]  px_r, py_r, sx_r, sy_r;
  logic              pos_ok_r;
  logic [SPAN_W-1:0] x0_r, ex_r, ey_r, x0_nxt, ex_nxt, ey_nxt;
  logic [SPAN_W-1:0] rd_row_r, rd_row_nxt, dat_row_r, dat_row_nxt;
  logic              dv_r, dv_nxt, rdv_r, rdv_nxt;
  logic              res_ok_r, res_hit_r, res_ok_nxt, res_hit_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic              out_valid_r, out_ok_r, out_hit_r;
  logic [ID_W-1:0]   out_id_r;
  logic [GRID_MAX_H-1:0] rv_r, rv_nxt;
  logic [NSLOT-1:0]  sv_r, sv_nxt;

  // grid row RAM signals
  logic              row_we;
  logic [YW-1:0]     row_waddr, row_raddr;
  logic [ROW_W-1:0]  row_wdata, row_rdata, row_eff, row_paint, row_clear;

  // saved position RAM signals
  logic              pos_we;
  logic [SW-1:0]     slot_v;
  logic [2*POS_W-1:0] pos_rdata;

  // derived values
  logic [SPAN_W-1:0] used_w, used_h;
  logic              in_acc, out_free, left_ok, top_ok;
  logic [GRID_MAX_W-1:0] lane_hit;
  logic              found;
  logic [ID_W-1:0]   found_id;

  // id to slot table, worked out at elaboration
  logic [SW-1:0] slot_tab [ID_SPAN];
  for (genvar g = 0; g < ID_SPAN; g++) begin : g_slot
    localparam int SL = g % MAX_OBJECTS;
    assign slot_tab[g] = SW'(SL);
  end
  assign slot_v = slot_tab[in_obj_id];

  // memories
  tgrc_ram #(.WIDTH(ROW_W), .DEPTH(GRID_MAX_H)) u_grid (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  tgrc_ram #(.WIDTH(2*POS_W), .DEPTH(MAX_OBJECTS)) u_pos (
    .clk   (clk),
    .we    (pos_we),
    .waddr (slot_v),
    .wdata ({in_pos_y, in_pos_x}),
    .raddr (slot_v),
    .rdata (pos_rdata)
  );

  // used area, clamped to the grid store
  assign used_w = (SPAN_W'(grid_w_r) > SPAN_W'(GRID_MAX_W)) ? SPAN_W'(GRID_MAX_W)
                                                             : SPAN_W'(grid_w_r);
  assign used_h = (SPAN_W'(grid_h_r) > SPAN_W'(GRID_MAX_H)) ? SPAN_W'(GRID_MAX_H)
                                                             : SPAN_W'(grid_h_r);
  assign left_ok = SPAN_W'(border_l_r) <= used_w;
  assign top_ok  = SPAN_W'(border_t_r) <= used_h;

  // handshakes
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign pos_we   = in_acc && (in_kind == K_PLACE);

  // row as read: a row never written since reset reads empty
  assign row_eff = rdv_r ? row_rdata : '0;

  // per-lane row logic: paint merge, scan compare, clear pattern
  always_comb begin
    logic in_x;
    logic brd;
    for (int x = 0; x < GRID_MAX_W; x++) begin
      in_x = (SPAN_W'(x) >= x0_r) && (SPAN_W'(x) < ex_r);
      row_paint[x*ID_W +: ID_W] = in_x ? ((kind_r == K_PLACE) ? id_r : '0)
                                       : row_eff[x*ID_W +: ID_W];
      lane_hit[x] = in_x && (row_eff[x*ID_W +: ID_W] != '0)
                         && (row_eff[x*ID_W +: ID_W] != id_r);
      brd = (left_ok && (SPAN_W'(x) < SPAN_W'(border_l_r)) && (rd_row_r < used_h))
         || (top_ok && (rd_row_r < SPAN_W'(border_t_r)) && (SPAN_W'(x) < used_w));
      row_clear[x*ID_W +: ID_W] = brd ? border_id_r : '0;
    end
  end

  // first hit from the left
  always_comb begin
    found    = 1'b0;
    found_id = '0;
    for (int x = GRID_MAX_W - 1; x >= 0; x--) begin
      if (lane_hit[x]) begin
        found    = 1'b1;
        found_id = row_eff[x*ID_W +: ID_W];
      end
    end
  end

  // sequencer
  always_comb begin
    logic [POS_W-1:0]  ox, oy;
    logic [SPAN_W-1:0] ex, ey;
    logic              inb, empty;
    state_nxt   = state_r;
    x0_nxt      = x0_r;
    ex_nxt      = ex_r;
    ey_nxt      = ey_r;
    rd_row_nxt  = rd_row_r;
    dat_row_nxt = dat_row_r;
    dv_nxt      = 1'b0;
    rdv_nxt     = rdv_r;
    res_ok_nxt  = res_ok_r;
    res_hit_nxt = res_hit_r;
    res_id_nxt  = res_id_r;
    rv_nxt      = rv_r;
    sv_nxt      = sv_r;
    row_we      = 1'b0;
    row_waddr   = dat_row_r[YW-1:0];
    row_wdata   = row_paint;
    row_raddr   = rd_row_r[YW-1:0];
    // rectangle origin: remove uses the saved position
    ox = px_r;
    oy = py_r;
    if (kind_r == K_REMOVE) begin
      ox = pos_ok_r ? pos_rdata[POS_W-1:0] : '0;
      oy = pos_ok_r ? pos_rdata[2*POS_W-1:POS_W] : '0;
    end
    ex    = SPAN_W'(ox) + SPAN_W'(sx_r);
    ey    = SPAN_W'(oy) + SPAN_W'(sy_r);
    inb   = (ex <= used_w) && (ey <= used_h);
    empty = (sx_r == '0) || (sy_r == '0);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SETUP;
          if (in_kind == K_PLACE) begin
            sv_nxt[slot_v[VW-1:0]] = 1'b1;
          end
        end
      end
      S_SETUP: begin
        x0_nxt      = SPAN_W'(ox);
        ex_nxt      = ex;
        ey_nxt      = ey;
        rd_row_nxt  = SPAN_W'(oy);
        res_ok_nxt  = 1'b0;
        res_hit_nxt = 1'b0;
        res_id_nxt  = '0;
        case (kind_r)
          K_CLEAR: begin
            rd_row_nxt = '0;
            state_nxt  = S_CLEAR;
          end
          K_QUERY: begin
            if (!inb) begin
              res_hit_nxt = 1'b1;
              res_id_nxt  = border_id_r;
              state_nxt   = S_DONE;
            end else if (empty) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_RUN;
            end
          end
          default: begin
            if (!inb || empty) begin
              res_ok_nxt = inb;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_RUN;
            end
          end
        endcase
      end
      S_CLEAR: begin
        // one row of the whole store per cycle
        row_we    = 1'b1;
        row_waddr = rd_row_r[YW-1:0];
        row_wdata = row_clear;
        rv_nxt[rd_row_r[YW-1:0]] = 1'b1;
        if (rd_row_r == SPAN_W'(GRID_MAX_H - 1)) begin
          res_ok_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          rd_row_nxt = rd_row_r + 1'b1;
        end
      end
      S_RUN: begin
        // read next row while the previous one is merged or scanned
        if (rd_row_r < ey_r) begin
          rd_row_nxt  = rd_row_r + 1'b1;
          dat_row_nxt = rd_row_r;
          dv_nxt      = 1'b1;
          rdv_nxt     = rv_r[rd_row_r[YW-1:0]];
        end
        if (dv_r) begin
          if (kind_r == K_QUERY) begin
            if (found) begin
              res_hit_nxt = 1'b1;
              res_id_nxt  = found_id;
              state_nxt   = S_DONE;
            end else if (dat_row_r + 1'b1 == ey_r) begin
              state_nxt = S_DONE;
            end
          end else begin
            row_we = 1'b1;
            rv_nxt[dat_row_r[YW-1:0]] = 1'b1;
            if (dat_row_r + 1'b1 == ey_r) begin
              res_ok_nxt = 1'b1;
              state_nxt  = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dv_r        <= 1'b0;
      rv_r        <= '0;
      sv_r        <= '0;
      out_valid_r <= 1'b0;
      grid_w_r    <= CFG_W'(64);
      grid_h_r    <= CFG_W'(64);
      border_l_r  <= '0;
      border_t_r  <= '0;
      border_id_r <= ID_W'(1);
    end else begin
      state_r <= state_nxt;
      dv_r    <= dv_nxt;
      rv_r    <= rv_nxt;
      sv_r    <= sv_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          R_GRID_W:   grid_w_r    <= cfg_wdata;
          R_GRID_H:   grid_h_r    <= cfg_wdata;
          R_BORDER_L: border_l_r  <= cfg_wdata;
          R_BORDER_T: border_t_r  <= cfg_wdata;
          R_BORDER_I: border_id_r <= cfg_wdata[ID_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x0_r      <= x0_nxt;
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    rd_row_r  <= rd_row_nxt;
    dat_row_r <= dat_row_nxt;
    rdv_r     <= rdv_nxt;
    res_ok_r  <= res_ok_nxt;
    res_hit_r <= res_hit_nxt;
    res_id_r  <= res_id_nxt;
    if (in_acc) begin
      kind_r   <= in_kind;
      id_r     <= in_obj_id;
      px_r     <= in_pos_x;
      py_r     <= in_pos_y;
      sx_r     <= in_size_x;
      sy_r     <= in_size_y;
      pos_ok_r <= sv_r[slot_v[VW-1:0]];
    end
    if (state_r == S_DONE && out_free) begin
      out_ok_r  <= res_ok_r;
      out_hit_r <= res_hit_r;
      out_id_r  <= res_id_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_ok     = out_ok_r;
  assign out_hit    = out_hit_r;
  assign out_hit_id = out_id_r;

  // a new result beat only comes from a finished command
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result beat without finished command");

  // a beat never reports both a paint success and a hit
  a_ok_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_ok_r && out_hit_r))
    else $error("ok and hit both set");

  // no hit means no id
  a_nohit_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_id_r == '0)
    else $error("hit id without hit");

  // rows handled by the row unit stay inside the rectangle
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN && dv_r |-> dat_row_r < ey_r)
    else $error("row beyond rectangle");

  // the sequencer leaves idle only on an accepted command
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && state_nxt != S_IDLE |-> in_valid)
    else $error("command started without input beat");

endmodule

### hdl/tgrc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tgrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### test/testbench.sv
// Self-checking testbench for tile_grid_rect_collision: directed edge cases, then
// random command traffic over several grid settings with random idling on both sides.
// Depends on tgrc_pkg and the tile_grid_rect_collision RTL.
module testbench;
  import tgrc_pkg::*;

  localparam int COLS_MAX         = 64;
  localparam int ROWS_MAX         = 64;
  localparam int ID_SLOTS         = 64;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 80;
  localparam int RANDOM_PER_PHASE = 200;

  typedef struct packed {
    logic            ok;
    logic            hit;
    logic [ID_W-1:0] hit_id;
  } grid_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [KIND_W-1:0] in_kind;
  logic [ID_W-1:0]   in_obj_id;
  logic [POS_W-1:0]  in_pos_x;
  logic [POS_W-1:0]  in_pos_y;
  logic [POS_W-1:0]  in_size_x;
  logic [POS_W-1:0]  in_size_y;
  logic              out_valid;
  logic              out_stall;
  logic              out_ok;
  logic              out_hit;
  logic [ID_W-1:0]   out_hit_id;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  // Shadow of the grid, the saved anchors and the registers
  logic [ID_W-1:0]  owner_mem [0:COLS_MAX*ROWS_MAX-1];
  logic [POS_W-1:0] anchor_x [0:ID_SLOTS-1];
  logic [POS_W-1:0] anchor_y [0:ID_SLOTS-1];
  int               reg_cols;
  int               reg_rows;
  int               reg_left;
  int               reg_top;
  logic [ID_W-1:0]  reg_border_id;

  // Last placed size per id, so removes mostly match their place
  int placed_w [0:ID_SLOTS-1];
  int placed_h [0:ID_SLOTS-1];

  grid_result_t pending [$];
  grid_result_t want;
  int           mismatches;
  int           beats_seen;
  int           quiet_cycles;
  int           calm_left [0:1];

  tile_grid_rect_collision dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_obj_id  (in_obj_id),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_size_x  (in_size_x),
    .in_size_y  (in_size_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_ok     (out_ok),
    .out_hit    (out_hit),
    .out_hit_id (out_hit_id),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Used area, grid registers clamp at the store size
  function int used_cols();
    return (reg_cols > COLS_MAX) ? COLS_MAX : reg_cols;
  endfunction

  function int used_rows();
    return (reg_rows > ROWS_MAX) ? ROWS_MAX : reg_rows;
  endfunction

  // Fill a rectangle; nothing happens if the far edge leaves the used area
  function automatic bit paint_rect(input int px, input int py, input int sx, input int sy,
                                    input logic [ID_W-1:0] id);
    int ex;
    int ey;
    int x;
    int y;
    ex = px + sx;
    ey = py + sy;
    if (ex > used_cols() || ey > used_rows())
      return 1'b0;
    for (y = py; y < ey; y++)
      for (x = px; x < ex; x++)
        owner_mem[y*COLS_MAX + x] = id;
    return 1'b1;
  endfunction

  // Apply one command to the shadow grid and return its result beat
  function automatic grid_result_t predict_command(input logic [KIND_W-1:0] kind,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [POS_W-1:0] px,
                                                   input logic [POS_W-1:0] py,
                                                   input logic [POS_W-1:0] sx,
                                                   input logic [POS_W-1:0] sy);
    grid_result_t r;
    int           cx;
    int           cy;
    int           wx;
    int           wy;
    int           x;
    int           y;
    bit           found;
    logic [ID_W-1:0] owner;
    r  = '0;
    cx = int'(px);
    cy = int'(py);
    wx = int'(sx);
    wy = int'(sy);
    case (kind)
      K_CLEAR: begin
        for (x = 0; x < COLS_MAX*ROWS_MAX; x++)
          owner_mem[x] = '0;
        void'(paint_rect(0, 0, reg_left, used_rows(), reg_border_id));
        void'(paint_rect(0, 0, used_cols(), reg_top, reg_border_id));
        r.ok = 1'b1;
      end
      K_PLACE: begin
        // anchor is saved even when the fill is out of bounds
        anchor_x[id] = px;
        anchor_y[id] = py;
        r.ok = paint_rect(cx, cy, wx, wy, id);
      end
      K_REMOVE: begin
        r.ok = paint_rect(int'(anchor_x[id]), int'(anchor_y[id]), wx, wy, '0);
      end
      default: begin
        if (cx + wx > used_cols() || cy + wy > used_rows()) begin
          r.hit    = 1'b1;
          r.hit_id = reg_border_id;
        end else begin
          // row-major scan, first foreign owner wins
          found = 1'b0;
          for (y = cy; y < cy + wy && !found; y++)
            for (x = cx; x < cx + wx && !found; x++) begin
              owner = owner_mem[y*COLS_MAX + x];
              if (owner != '0 && owner != id) begin
                found    = 1'b1;
                r.hit    = 1'b1;
                r.hit_id = owner;
              end
            end
        end
      end
    endcase
    return r;
  endfunction

  // Per-beat wait draw, with occasional stretches of no idling
  function automatic int next_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Send one command beat; the expected result is queued on acceptance
  task automatic send_command(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                              input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                              input logic [POS_W-1:0] sx, input logic [POS_W-1:0] sy);
    int gap;
    gap = next_wait(0);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_obj_id <= id;
    in_pos_x  <= px;
    in_pos_y  <= py;
    in_size_x <= sx;
    in_size_y <= sy;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending.push_back(predict_command(kind, id, px, py, sx, sy));
  endtask

  // Drop valid and wait until every result is back and the block is idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    case (idx)
      R_GRID_W:   reg_cols      = value & 127;
      R_GRID_H:   reg_rows      = value & 127;
      R_BORDER_L: reg_left      = value & 127;
      R_BORDER_T: reg_top       = value & 127;
      R_BORDER_I: reg_border_id = value[ID_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input int cols, input int rows, input int left, input int top,
                                input int border);
    settle();
    write_reg(R_GRID_W, cols);
    write_reg(R_GRID_H, rows);
    write_reg(R_BORDER_L, left);
    write_reg(R_BORDER_T, top);
    write_reg(R_BORDER_I, border);
  endtask

  // Fresh grid with default registers
  task automatic test_after_reset();
    send_command(K_QUERY, 6'd5, 7'd0, 7'd0, 7'd64, 7'd64);
    // remove of a never-placed object uses anchor (0,0)
    send_command(K_REMOVE, 6'd9, 7'd0, 7'd0, 7'd2, 7'd2);
    send_command(K_QUERY, 6'd5, 7'd63, 7'd0, 7'd2, 7'd1);
    send_command(K_CLEAR, 6'd1, 7'd0, 7'd0, 7'd0, 7'd0);
  endtask

  // Borders, bounds, empty rectangles and field extremes
  task automatic test_directed_edges();
    apply_settings(64, 64, 2, 3, 63);
    send_command(K_CLEAR, 6'd1, 7'd0, 7'd0, 7'd0, 7'd0);
    send_command(K_QUERY, 6'd7, 7'd0, 7'd0, 7'd1, 7'd1);
    // asking as the border id skips border cells
    send_command(K_QUERY, 6'd63, 7'd0, 7'd0, 7'd10, 7'd10);
    send_command(K_PLACE, 6'd10, 7'd60, 7'd60, 7'd4, 7'd4);
    send_command(K_PLACE, 6'd11, 7'd61, 7'd60, 7'd4, 7'd4);
    send_command(K_REMOVE, 6'd11, 7'd0, 7'd0, 7'd1, 7'd1);
    send_command(K_QUERY, 6'd1, 7'd58, 7'd58, 7'd6, 7'd6);
    // overrun still reports the border, even to the border id
    send_command(K_QUERY, 6'd63, 7'd60, 7'd63, 7'd5, 7'd1);
    send_command(K_PLACE, 6'd20, 7'd10, 7'd10, 7'd0, 7'd5);
    send_command(K_QUERY, 6'd1, 7'd10, 7'd10, 7'd0, 7'd0);
    send_command(K_PLACE, 6'd0, 7'd60, 7'd60, 7'd1, 7'd1);
    send_command(K_PLACE, 6'd63, 7'd127, 7'd127, 7'd127, 7'd127);
    send_command(K_QUERY, 6'd0, 7'd127, 7'd127, 7'd127, 7'd127);
    send_command(K_REMOVE, 6'd63, 7'd0, 7'd0, 7'd0, 7'd0);
    send_command(K_QUERY, 6'd3, 7'd2, 7'd3, 7'd62, 7'd61);
    send_command(K_CLEAR, 6'd63, 7'd0, 7'd0, 7'd0, 7'd0);
  endtask

  // Random commands: mostly in-bounds rectangles over a small id pool, some noise
  task automatic run_random_items(input int count);
    int              n;
    int              pick;
    int              uc;
    int              ur;
    int              hi;
    int              sx;
    int              sy;
    int              px;
    int              py;
    logic [ID_W-1:0] id;
    for (n = 0; n < count; n++) begin
      uc   = used_cols();
      ur   = used_rows();
      pick = $urandom_range(0, 99);
      id   = ID_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(1, 12));
      hi   = (uc < 8) ? uc : 8;
      sx   = $urandom_range(1, hi);
      hi   = (ur < 8) ? ur : 8;
      sy   = $urandom_range(1, hi);
      if ($urandom_range(0, 11) == 0) begin
        sx = $urandom_range(0, uc);
        sy = $urandom_range(0, ur);
      end
      px = $urandom_range(0, uc - sx);
      py = $urandom_range(0, ur - sy);
      if (pick < 4) begin
        send_command(K_CLEAR, id, POS_W'(px), POS_W'(py), POS_W'(sx), POS_W'(sy));
      end else if (pick < 36) begin
        placed_w[id] = sx;
        placed_h[id] = sy;
        send_command(K_PLACE, id, POS_W'(px), POS_W'(py), POS_W'(sx), POS_W'(sy));
      end else if (pick < 56) begin
        if ($urandom_range(0, 6) != 0) begin
          sx = placed_w[id];
          sy = placed_h[id];
        end
        send_command(K_REMOVE, id, POS_W'(px), POS_W'(py), POS_W'(sx), POS_W'(sy));
      end else if (pick < 90) begin
        if ($urandom_range(0, 9) == 0) begin
          px = $urandom_range(0, uc);
          sx = uc - px + $urandom_range(1, 4);
        end
        send_command(K_QUERY, id, POS_W'(px), POS_W'(py), POS_W'(sx), POS_W'(sy));
      end else begin
        send_command(KIND_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, 63)),
                     POS_W'($urandom_range(0, 127)), POS_W'($urandom_range(0, 127)),
                     POS_W'($urandom_range(0, 127)), POS_W'($urandom_range(0, 127)));
      end
    end
  endtask

  // Random traffic across several grid and border settings
  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_settings(8, 6, 1, 1, 7);
        1: apply_settings(127, 100, 3, 2, 63);
        2: apply_settings(1, 1, 1, 0, 5);
        3: apply_settings(16, 12, 20, 64, 9);
        4: apply_settings(64, 64, 64, 0, 2);
        default: apply_settings($urandom_range(2, 64), $urandom_range(2, 64),
                                $urandom_range(0, 8), $urandom_range(0, 8),
                                $urandom_range(1, 63));
      endcase
      run_random_items(RANDOM_PER_PHASE);
    end
  endtask

  // Result side: random stall per beat
  initial begin
    int hold;
    out_stall = 1'b1;
    forever begin
      hold = next_wait(1);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Compare each result beat with the oldest expected one
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      beats_seen++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with no command pending", beats_seen));
      end else begin
        want = pending.pop_front();
        if (out_ok !== want.ok)
          report_mismatch($sformatf("beat %0d ok %b, want %b", beats_seen, out_ok, want.ok));
        if (out_hit !== want.hit)
          report_mismatch($sformatf("beat %0d hit %b, want %b", beats_seen, out_hit,
                                    want.hit));
        if (out_hit_id !== want.hit_id)
          report_mismatch($sformatf("beat %0d hit_id %0d, want %0d", beats_seen, out_hit_id,
                                    want.hit_id));
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int i;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = K_CLEAR;
    in_obj_id    = '0;
    in_pos_x     = '0;
    in_pos_y     = '0;
    in_size_x    = '0;
    in_size_y    = '0;
    cfg_we       = 1'b0;
    cfg_index    = R_GRID_W;
    cfg_wdata    = '0;
    mismatches   = 0;
    beats_seen   = 0;
    quiet_cycles = 0;
    calm_left[0] = 0;
    calm_left[1] = 0;
    // shadow state after reset
    reg_cols      = 64;
    reg_rows      = 64;
    reg_left      = 0;
    reg_top       = 0;
    reg_border_id = 6'd1;
    for (i = 0; i < COLS_MAX*ROWS_MAX; i++)
      owner_mem[i] = '0;
    for (i = 0; i < ID_SLOTS; i++) begin
      anchor_x[i] = '0;
      anchor_y[i] = '0;
      placed_w[i] = 1;
      placed_h[i] = 1;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_directed_edges();
    test_random_traffic();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
hdl/tgrc_pkg.sv
hdl/tgrc_ram.sv
hdl/tile_grid_rect_collision.sv
test/testbench.sv
